>>> rtl/lmss_pkg.sv
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types, codes and defaults for the LED matrix scroll scanner.
// ----------------------------------------------------------------------------
package lmss_pkg;

   localparam int MODE_W       = 3;
   localparam int COLUMN_W     = 7;
   localparam int PIXELS_W     = 16;
   localparam int SCAN_INDEX_W = 5;

   localparam int HALF_COLUMNS_DEF   = 32;
   localparam int HIDDEN_COLUMNS_DEF = 20;
   localparam int ROW_BITS_DEF       = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCOUNT_W    = 2;

   localparam logic [MODE_W-1:0] MODE_OR_WRITE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STORE    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SCROLL   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SCAN     = 3'd4;

   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_OR     = 3'd0;
   localparam logic [OP_W-1:0] OP_STORE  = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
   localparam logic [OP_W-1:0] OP_SCROLL = 3'd3;
   localparam logic [OP_W-1:0] OP_SCAN   = 3'd4;

   localparam int REGION_W = 2;
   localparam logic [REGION_W-1:0] REGION_LEFT   = 2'd0;
   localparam logic [REGION_W-1:0] REGION_RIGHT  = 2'd1;
   localparam logic [REGION_W-1:0] REGION_HIDDEN = 2'd2;
   localparam logic [REGION_W-1:0] REGION_NONE   = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [COLUMN_W-1:0] column;
      logic [PIXELS_W-1:0] pixels;
   } req_type;

   typedef struct packed {
      logic                    upper_bit;
      logic                    lower_bit;
      logic [SCAN_INDEX_W-1:0] scan_index;
      logic                    frame_start;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [REGION_W-1:0] region;
      logic [COLUMN_W-1:0] index;
      logic [PIXELS_W-1:0] pixels;
   } op_type;

endpackage

>>> rtl/lmss_front.sv
// ----------------------------------------------------------------------------
// lmss_front
// Decodes a request into an operation and resolves the target column region.
// ----------------------------------------------------------------------------
module lmss_front #(
   parameter int HALF_COLUMNS   = lmss_pkg::HALF_COLUMNS_DEF,
   parameter int HIDDEN_COLUMNS = lmss_pkg::HIDDEN_COLUMNS_DEF
) (
   input  lmss_pkg::req_type req,
   output logic              op_valid,
   output lmss_pkg::op_type  op
);

   localparam int RIGHT_END  = 2 * HALF_COLUMNS;
   localparam int HIDDEN_END = RIGHT_END + HIDDEN_COLUMNS;

   int col;

   always_comb begin
      col       = int'(req.column);
      op.pixels = req.pixels;
      op.index  = '0;
      if (col < HALF_COLUMNS) begin
         op.region = lmss_pkg::REGION_LEFT;
         op.index  = req.column;
      end else if (col < RIGHT_END) begin
         op.region = lmss_pkg::REGION_RIGHT;
         op.index  = lmss_pkg::COLUMN_W'(col - HALF_COLUMNS);
      end else if (col < HIDDEN_END) begin
         op.region = lmss_pkg::REGION_HIDDEN;
         op.index  = lmss_pkg::COLUMN_W'(col - RIGHT_END);
      end else begin
         op.region = lmss_pkg::REGION_NONE;
      end

      unique case (req.mode)
         lmss_pkg::MODE_OR_WRITE: begin
            op.op    = lmss_pkg::OP_OR;
            op_valid = (op.region == lmss_pkg::REGION_LEFT) ||
                       (op.region == lmss_pkg::REGION_RIGHT);
         end
         lmss_pkg::MODE_STORE: begin
            op.op    = lmss_pkg::OP_STORE;
            op_valid = (op.region != lmss_pkg::REGION_NONE);
         end
         lmss_pkg::MODE_CLEAR: begin
            op.op    = lmss_pkg::OP_CLEAR;
            op_valid = 1'b1;
         end
         lmss_pkg::MODE_SCROLL: begin
            op.op    = lmss_pkg::OP_SCROLL;
            op_valid = 1'b1;
         end
         lmss_pkg::MODE_SCAN: begin
            op.op    = lmss_pkg::OP_SCAN;
            op_valid = 1'b1;
         end
         default: begin
            op.op    = lmss_pkg::OP_CLEAR;
            op_valid = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/lmss_queue.sv
// ----------------------------------------------------------------------------
// lmss_queue
// Two-entry operation queue between the decoder and the column engine.
// ----------------------------------------------------------------------------
module lmss_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lmss_pkg::op_type push_op,
   input  logic             pop,
   output lmss_pkg::op_type head_op,
   output logic             empty,
   output logic             full
);

   lmss_pkg::op_type                    mem_ff [lmss_pkg::QUEUE_DEPTH];
   logic [lmss_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [lmss_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [lmss_pkg::QCOUNT_W-1:0]       count_ff, count_in;
   logic                                do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == lmss_pkg::QCOUNT_W'(lmss_pkg::QUEUE_DEPTH));
   assign head_op = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + lmss_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + lmss_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + lmss_pkg::QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - lmss_pkg::QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

>>> rtl/lmss_back.sv
// ----------------------------------------------------------------------------
// lmss_back
// Column store engine: writes, clear, scroll, and row-serial column scan.
// ----------------------------------------------------------------------------
module lmss_back #(
   parameter int HALF_COLUMNS   = lmss_pkg::HALF_COLUMNS_DEF,
   parameter int HIDDEN_COLUMNS = lmss_pkg::HIDDEN_COLUMNS_DEF,
   parameter int ROW_BITS       = lmss_pkg::ROW_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_ready,
   input  lmss_pkg::op_type  op,
   output logic              op_pop,
   output logic              rsp_strobe,
   output lmss_pkg::rsp_type rsp_data
);

   localparam int PW = $clog2(HALF_COLUMNS);
   localparam int RW = $clog2(ROW_BITS);
   localparam logic [PW-1:0] POS_TOP  = PW'(HALF_COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROW_BITS - 1);

   logic [ROW_BITS-1:0] left_ff   [HALF_COLUMNS];
   logic [ROW_BITS-1:0] left_in   [HALF_COLUMNS];
   logic [ROW_BITS-1:0] right_ff  [HALF_COLUMNS];
   logic [ROW_BITS-1:0] right_in  [HALF_COLUMNS];
   logic [ROW_BITS-1:0] hidden_ff [HIDDEN_COLUMNS];
   logic [ROW_BITS-1:0] hidden_in [HIDDEN_COLUMNS];

   logic [PW-1:0]                     pos_ff, pos_in;
   logic                              scanning_ff, scanning_in;
   logic [RW-1:0]                     row_ff, row_in;
   logic [ROW_BITS-1:0]               upper_sh_ff, upper_sh_in;
   logic [ROW_BITS-1:0]               lower_sh_ff, lower_sh_in;
   logic [lmss_pkg::SCAN_INDEX_W-1:0] index_ff, index_in;
   logic                              frame_ff, frame_in;
   logic                              last_row;
   logic [ROW_BITS-1:0]               pix;

   assign last_row   = (row_ff == LAST_ROW);
   assign op_pop     = op_ready && (!scanning_ff || last_row);
   assign pix        = ROW_BITS'(op.pixels);
   assign rsp_strobe = scanning_ff;

   always_comb begin
      rsp_data.upper_bit   = upper_sh_ff[0];
      rsp_data.lower_bit   = lower_sh_ff[0];
      rsp_data.scan_index  = index_ff;
      rsp_data.frame_start = frame_ff;
      rsp_data.last        = last_row;
   end

   always_comb begin
      left_in     = left_ff;
      right_in    = right_ff;
      hidden_in   = hidden_ff;
      pos_in      = pos_ff;
      scanning_in = scanning_ff;
      row_in      = row_ff;
      upper_sh_in = upper_sh_ff;
      lower_sh_in = lower_sh_ff;
      index_in    = index_ff;
      frame_in    = frame_ff;

      if (scanning_ff) begin
         upper_sh_in = upper_sh_ff >> 1;
         lower_sh_in = lower_sh_ff >> 1;
         row_in      = row_ff + RW'(1);
         if (last_row) begin
            scanning_in = 1'b0;
         end
      end

      if (op_pop) begin
         unique case (op.op)
            lmss_pkg::OP_OR, lmss_pkg::OP_STORE: begin
               for (int i = 0; i < HALF_COLUMNS; i++) begin
                  if (op.index == lmss_pkg::COLUMN_W'(i)) begin
                     if (op.region == lmss_pkg::REGION_LEFT) begin
                        left_in[i] = (op.op == lmss_pkg::OP_OR) ? (left_ff[i] | pix) : pix;
                     end
                     if (op.region == lmss_pkg::REGION_RIGHT) begin
                        right_in[i] = (op.op == lmss_pkg::OP_OR) ? (right_ff[i] | pix) : pix;
                     end
                  end
               end
               for (int i = 0; i < HIDDEN_COLUMNS; i++) begin
                  if ((op.index == lmss_pkg::COLUMN_W'(i)) &&
                      (op.region == lmss_pkg::REGION_HIDDEN) &&
                      (op.op == lmss_pkg::OP_STORE)) begin
                     hidden_in[i] = pix;
                  end
               end
            end
            lmss_pkg::OP_CLEAR: begin
               for (int i = 0; i < HALF_COLUMNS; i++) begin
                  left_in[i]  = '0;
                  right_in[i] = '0;
               end
            end
            lmss_pkg::OP_SCROLL: begin
               for (int i = 0; i < HALF_COLUMNS - 1; i++) begin
                  left_in[i]  = left_ff[i + 1];
                  right_in[i] = right_ff[i + 1];
               end
               left_in[HALF_COLUMNS - 1]  = right_ff[0];
               right_in[HALF_COLUMNS - 1] = hidden_ff[0];
               for (int i = 0; i < HIDDEN_COLUMNS - 1; i++) begin
                  hidden_in[i] = hidden_ff[i + 1];
               end
               hidden_in[HIDDEN_COLUMNS - 1] = '0;
            end
            lmss_pkg::OP_SCAN: begin
               upper_sh_in = left_ff[pos_ff];
               lower_sh_in = right_ff[pos_ff];
               index_in    = lmss_pkg::SCAN_INDEX_W'(pos_ff);
               frame_in    = (pos_ff == POS_TOP);
               pos_in      = (pos_ff == '0) ? POS_TOP : pos_ff - PW'(1);
               row_in      = '0;
               scanning_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HALF_COLUMNS; i++) begin
            left_ff[i]  <= '0;
            right_ff[i] <= '0;
         end
         for (int i = 0; i < HIDDEN_COLUMNS; i++) begin
            hidden_ff[i] <= '0;
         end
         pos_ff      <= POS_TOP;
         scanning_ff <= 1'b0;
         row_ff      <= '0;
      end else begin
         left_ff     <= left_in;
         right_ff    <= right_in;
         hidden_ff   <= hidden_in;
         pos_ff      <= pos_in;
         scanning_ff <= scanning_in;
         row_ff      <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      upper_sh_ff <= upper_sh_in;
      lower_sh_ff <= lower_sh_in;
      index_ff    <= index_in;
      frame_ff    <= frame_in;
   end

endmodule

>>> rtl/led_matrix_scroll_scanner_top.sv
// ----------------------------------------------------------------------------
// led_matrix_scroll_scanner_top
// LED matrix column store with scroll buffer and row-serial column scanner.
// ----------------------------------------------------------------------------
// Write, clear and scroll transactions are applied by the column engine when it pops them.
// A scan emits ROW_BITS row bits (16 by default): one row bit per cycle from the shifters.
// On an idle engine, an accepted scan passes the queue entry, then the scan shifters.
// A two-entry queue decouples the decoder; busy is high while it is full.
// Results cannot be stalled. Reset clears all columns, sets scan position to
// HALF_COLUMNS-1 and empties the queue.
module led_matrix_scroll_scanner_top #(
   parameter int HALF_COLUMNS   = lmss_pkg::HALF_COLUMNS_DEF,
   parameter int HIDDEN_COLUMNS = lmss_pkg::HIDDEN_COLUMNS_DEF,
   parameter int ROW_BITS       = lmss_pkg::ROW_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lmss_pkg::req_type req_data,
   output logic              rsp_strobe,
   output lmss_pkg::rsp_type rsp_data
);

   lmss_pkg::op_type dec_op;
   lmss_pkg::op_type head_op;
   logic             dec_valid;
   logic             q_empty;
   logic             q_full;
   logic             q_pop;

   assign busy = q_full;

   lmss_front #(
      .HALF_COLUMNS  (HALF_COLUMNS),
      .HIDDEN_COLUMNS(HIDDEN_COLUMNS)
   ) u_front (
      .req     (req_data),
      .op_valid(dec_valid),
      .op      (dec_op)
   );

   lmss_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (start && !busy && dec_valid),
      .push_op(dec_op),
      .pop    (q_pop),
      .head_op(head_op),
      .empty  (q_empty),
      .full   (q_full)
   );

   lmss_back #(
      .HALF_COLUMNS  (HALF_COLUMNS),
      .HIDDEN_COLUMNS(HIDDEN_COLUMNS),
      .ROW_BITS      (ROW_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_ready  (!q_empty),
      .op        (head_op),
      .op_pop    (q_pop),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("results or busy after reset");

   a_scan_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("scan burst broken");

   a_scan_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=>
         $stable(rsp_data.scan_index) && $stable(rsp_data.frame_start))
      else $error("scan column changed within burst");

   a_frame_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.frame_start |->
         rsp_data.scan_index == lmss_pkg::SCAN_INDEX_W'(HALF_COLUMNS - 1))
      else $error("frame start on wrong column");

endmodule
